[hdl/amr_pkg.sv]
`timescale 1ns / 1ps
package amr_pkg;
  localparam int BASE_SIZE = 4;
  localparam int MAX_LEVEL = 4;
  localparam int VALUE_BITS = 32;
  localparam int LEV_W = 3;
  localparam int COORD_W = 6;
  localparam int TABLE_DEPTH = BASE_SIZE * BASE_SIZE * ((1 << (2 * (MAX_LEVEL + 1))) - 1) / 3;
  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int ENTRY_W = VALUE_BITS + 1;
  localparam int SUM_W = 64;
  localparam int STACK_D = MAX_LEVEL + 1;
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              we;
    logic              re;
    logic [ENTRY_W-1:0] wdata;
  } mem_req_t;

  function automatic logic [ADDR_W-1:0] level_base(input logic [LEV_W-1:0] lev);
    logic [ADDR_W-1:0] b;
    b = '0;
    for (int i = 0; i <= MAX_LEVEL; i++) begin
      if (LEV_W'(i) == lev) begin
        b = ADDR_W'(BASE_SIZE * BASE_SIZE * ((1 << (2 * i)) - 1) / 3);
      end
    end
    return b;
  endfunction

  function automatic logic [ADDR_W-1:0] slot(input logic [LEV_W-1:0] lev,
                                             input logic [COORD_W-1:0] col,
                                             input logic [COORD_W-1:0] row);
    logic [ADDR_W-1:0] off;
    off = '0;
    for (int i = 0; i <= MAX_LEVEL; i++) begin
      if (LEV_W'(i) == lev) begin
        off = ADDR_W'(row) * ADDR_W'(BASE_SIZE << i) + ADDR_W'(col);
      end
    end
    return level_base(lev) + off;
  endfunction

  function automatic logic [COORD_W:0] extent(input logic [LEV_W-1:0] lev);
    logic [COORD_W:0] e;
    e = '0;
    for (int i = 0; i <= MAX_LEVEL; i++) begin
      if (LEV_W'(i) == lev) begin
        e = (COORD_W+1)'(BASE_SIZE << i);
      end
    end
    return e;
  endfunction
endpackage

[hdl/amr_table_ram.sv]
`timescale 1ns / 1ps
module amr_table_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end
endmodule

[hdl/amr_average.sv]
`timescale 1ns / 1ps
module amr_average (
  input  logic                                 clk,
  input  logic                                 start,
  input  logic [amr_pkg::SUM_W-1:0]            sum,
  input  logic [amr_pkg::LEV_W-1:0]            lev,
  output logic [amr_pkg::VALUE_BITS-1:0]       result
);
  localparam logic [amr_pkg::SUM_W-1:0] LIM = amr_pkg::SUM_W'(1) << (amr_pkg::VALUE_BITS - 1);
  logic [amr_pkg::SUM_W-1:0] rnd_r;
  logic [6:0]                k_r;
  logic [6:0]                k;
  logic [amr_pkg::SUM_W-1:0] q;
  logic [amr_pkg::SUM_W-1:0] rnd_nxt;

  always_comb begin
    k = 7'(2 * (amr_pkg::MAX_LEVEL - int'(lev)));
    rnd_nxt = sum;
    if (k != 0) begin
      rnd_nxt = sum + (amr_pkg::SUM_W'(1) << (k - 7'd1));
    end
    q = rnd_r[amr_pkg::SUM_W-1] ? ~((~rnd_r) >> k_r) : (rnd_r >> k_r);
    if (q[amr_pkg::SUM_W-1]) begin
      result = (~q >= LIM) ? LIM[amr_pkg::VALUE_BITS-1:0] : q[amr_pkg::VALUE_BITS-1:0];
    end else begin
      result = (q >= LIM) ? amr_pkg::VALUE_BITS'(LIM - 1) : q[amr_pkg::VALUE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rnd_r <= rnd_nxt;
      k_r <= k;
    end
  end
endmodule

[hdl/amr_walker.sv]
`timescale 1ns / 1ps
module amr_walker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             req_valid,
  output logic                             req_ready,
  input  logic                             req_cmd,
  input  logic [amr_pkg::LEV_W-1:0]        req_lev,
  input  logic [amr_pkg::COORD_W-1:0]      req_col,
  input  logic [amr_pkg::COORD_W-1:0]      req_row,
  input  logic [amr_pkg::VALUE_BITS-1:0]   req_val,
  output amr_pkg::mem_req_t                mem,
  input  logic [amr_pkg::ENTRY_W-1:0]      mem_rdata,
  output logic                             res_valid,
  input  logic                             res_ready,
  output logic [amr_pkg::VALUE_BITS-1:0]   res_data
);
  typedef enum logic [3:0] {
    S_IDLE, S_INS_UP, S_PROBE, S_PROBE_CHK, S_DFS, S_DFS_CHK, S_AVG, S_AVG2, S_OUT
  } state_t;

  localparam int V = amr_pkg::VALUE_BITS;
  localparam int CW = amr_pkg::COORD_W;
  localparam int LW = amr_pkg::LEV_W;
  localparam int SD = amr_pkg::STACK_D;

  state_t state_r;
  logic [LW-1:0] lev_r, qlev_r, pl_r;
  logic [CW-1:0] col_r, row_r, qcol_r, qrow_r;
  logic [1:0]    kst_r [SD];
  logic [CW-1:0] pcol_r [SD];
  logic [CW-1:0] prow_r [SD];
  logic [LW-1:0] dep_r;
  logic [amr_pkg::SUM_W-1:0] sum_r;
  logic [V-1:0]  out_r;
  logic [V-1:0]  avg_res;
  logic          ok;
  logic [LW-1:0] d;
  logic [LW-1:0] clev;
  logic [CW-1:0] ccol, crow;
  logic [amr_pkg::SUM_W-1:0] sext;
  logic [LW-1:0] dtop;

  assign ok = (req_lev <= LW'(amr_pkg::MAX_LEVEL)) &&
              ({1'b0, req_col} < amr_pkg::extent(req_lev)) &&
              ({1'b0, req_row} < amr_pkg::extent(req_lev));
  assign d = qlev_r - pl_r;
  assign dtop = dep_r - LW'(1);
  assign clev = qlev_r + dep_r;
  assign ccol = CW'({pcol_r[dtop], kst_r[dtop][0]});
  assign crow = CW'({prow_r[dtop], kst_r[dtop][1]});
  assign sext = amr_pkg::SUM_W'($signed(mem_rdata[V-1:0]))
                << (2 * (amr_pkg::MAX_LEVEL - int'(clev)));
  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_OUT);
  assign res_data = out_r;

  amr_average u_avg (
    .clk(clk), .start(state_r == S_AVG), .sum(sum_r), .lev(qlev_r), .result(avg_res)
  );

  always_comb begin
    mem = '0;
    case (state_r)
      S_IDLE: begin
        mem.we = req_valid && ok && req_cmd == amr_pkg::CMD_INSERT;
        mem.addr = amr_pkg::slot(req_lev, req_col, req_row);
        mem.wdata = {1'b0, req_val};
      end
      S_INS_UP: begin
        mem.we = 1'b1;
        mem.addr = amr_pkg::slot(lev_r - LW'(1), col_r >> 1, row_r >> 1);
        mem.wdata = {1'b1, {V{1'b0}}};
      end
      S_PROBE: begin
        mem.re = 1'b1;
        mem.addr = amr_pkg::slot(pl_r, qcol_r >> d, qrow_r >> d);
      end
      S_DFS: begin
        mem.re = 1'b1;
        mem.addr = amr_pkg::slot(clev, ccol, crow);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (req_valid) begin
            lev_r <= req_lev; col_r <= req_col; row_r <= req_row;
            qlev_r <= req_lev; qcol_r <= req_col; qrow_r <= req_row;
            pl_r <= '0;
            out_r <= '0;
            if (req_cmd == amr_pkg::CMD_INSERT) begin
              if (ok && !req_col[0] && !req_row[0] && req_lev != '0) begin
                state_r <= S_INS_UP;
              end
            end else begin
              state_r <= ok ? S_PROBE : S_OUT;
            end
          end
        end
        S_INS_UP: begin
          lev_r <= lev_r - LW'(1);
          col_r <= col_r >> 1;
          row_r <= row_r >> 1;
          if (col_r[1] || row_r[1] || lev_r == LW'(1)) begin
            state_r <= S_IDLE;
          end
        end
        S_PROBE: state_r <= S_PROBE_CHK;
        S_PROBE_CHK: begin
          if (!mem_rdata[V] || pl_r == LW'(amr_pkg::MAX_LEVEL)) begin
            out_r <= mem_rdata[V-1:0];
            state_r <= S_OUT;
          end else if (pl_r == qlev_r) begin
            sum_r <= '0;
            dep_r <= LW'(1);
            kst_r[0] <= '0;
            pcol_r[0] <= qcol_r;
            prow_r[0] <= qrow_r;
            state_r <= S_DFS;
          end else begin
            pl_r <= pl_r + LW'(1);
            state_r <= S_PROBE;
          end
        end
        S_DFS: state_r <= S_DFS_CHK;
        S_DFS_CHK: begin
          if (mem_rdata[V] && clev < LW'(amr_pkg::MAX_LEVEL)) begin
            kst_r[dep_r] <= '0;
            pcol_r[dep_r] <= ccol;
            prow_r[dep_r] <= crow;
            dep_r <= dep_r + LW'(1);
            state_r <= S_DFS;
          end else begin
            sum_r <= sum_r + sext;
            if (kst_r[dtop] != 2'd3) begin
              kst_r[dtop] <= kst_r[dtop] + 2'd1;
              state_r <= S_DFS;
            end else begin
              logic [LW-1:0] dd;
              logic          done;
              dd = dtop;
              done = 1'b1;
              for (int i = SD - 1; i >= 0; i--) begin
                if (LW'(i) < dtop && done) begin
                  if (kst_r[i] != 2'd3) begin
                    done = 1'b0;
                    dd = LW'(i);
                  end
                end
              end
              if (done) begin
                state_r <= S_AVG;
              end else begin
                kst_r[dd] <= kst_r[dd] + 2'd1;
                dep_r <= dd + LW'(1);
                state_r <= S_DFS;
              end
            end
          end
        end
        S_AVG: state_r <= S_AVG2;
        S_AVG2: begin
          out_r <= avg_res;
          state_r <= S_OUT;
        end
        S_OUT: if (res_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

[hdl/amr_hierarchical_remap.sv]
`timescale 1ns / 1ps
// one request at a time: an insert writes its cell when taken and then marks its ancestors as
// refined (up to four); a query probes the table memory level by level and, over a refined
// cell, reads each descendant in a depth-first walk and then averages them; the single-port
// table memory serialises these accesses. the result waits in an output register and
// blocks new requests until it is taken
module amr_hierarchical_remap (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // command, cell_level, cell_col, cell_row, cell_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // remapped_value
);
  amr_pkg::mem_req_t mem;
  logic [amr_pkg::ENTRY_W-1:0] rdata;

  amr_table_ram #(.DEPTH(amr_pkg::TABLE_DEPTH), .WIDTH(amr_pkg::ENTRY_W)) u_ram (
    .clk(clk), .we(mem.we), .re(mem.re), .addr(mem.addr), .wdata(mem.wdata), .rdata(rdata)
  );

  amr_walker u_walk (
    .clk(clk), .rst_n(rst_n),
    .req_valid(in_tvalid), .req_ready(in_tready),
    .req_cmd(in_tdata[0]), .req_lev(in_tdata[3:1]),
    .req_col(in_tdata[9:4]), .req_row(in_tdata[15:10]), .req_val(in_tdata[47:16]),
    .mem(mem), .mem_rdata(rdata),
    .res_valid(out_tvalid), .res_ready(out_tready), .res_data(out_tdata)
  );

  a_no_rw: assert property (@(posedge clk) disable iff (!rst_n) !(mem.we && mem.re))
    else $error("table read and write together");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n) out_tvalid |-> !in_tready)
    else $error("request taken with result pending");
endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;

  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic                      cmd;
    logic [amr_pkg::LEV_W-1:0] lev;
    logic [5:0]                col;
    logic [5:0]                row;
    logic [31:0]               val;
  } cell_req_t;

  typedef struct {
    cell_req_t   req;
    bit          known;
    logic [31:0] remap;
  } step_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  amr_hierarchical_remap i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // shadow of the level table
  bit          cell_refined [amr_pkg::TABLE_DEPTH];
  logic [31:0] cell_value   [amr_pkg::TABLE_DEPTH];
  bit          cell_written [amr_pkg::TABLE_DEPTH];
  bit          unwritten_hit;

  logic [31:0] remap_due[$];
  int          mismatches = 0;
  int          issued;
  int          gap_pct;
  int          stall_pct;
  bit          pressure_go;
  int          held = 0;
  int          idle_cycles = 0;
  cell_req_t   mesh_cells[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int addr_of(int l, int c, int r);
    return amr_pkg::BASE_SIZE * amr_pkg::BASE_SIZE * ((1 << (2 * l)) - 1) / 3
           + r * (amr_pkg::BASE_SIZE << l) + c;
  endfunction

  function automatic bit on_mesh(int l, int c, int r);
    return l <= amr_pkg::MAX_LEVEL && c < (amr_pkg::BASE_SIZE << l)
           && r < (amr_pkg::BASE_SIZE << l);
  endfunction

  function automatic int touch(int s);
    if (!cell_written[s]) unwritten_hit = 1'b1;
    return s;
  endfunction

  function automatic void store_cell(int l, int c, int r, logic [31:0] v);
    int s;
    if (!on_mesh(l, c, r)) return;
    s = addr_of(l, c, r);
    cell_refined[s] = 1'b0;
    cell_value[s] = v;
    cell_written[s] = 1'b1;
    while (c % 2 == 0 && r % 2 == 0 && l > 0) begin
      c = c / 2;
      r = r / 2;
      l--;
      s = addr_of(l, c, r);
      cell_refined[s] = 1'b1;
      cell_value[s] = '0;
      cell_written[s] = 1'b1;
    end
  endfunction

  // leaves below a cell, weighted in units of the finest level
  function automatic longint weighted_below(int l, int c, int r);
    longint acc;
    int     cl;
    int     cc;
    int     rr;
    int     s;
    acc = 0;
    cl = l + 1;
    if (cl > amr_pkg::MAX_LEVEL) return 0;
    for (int k = 0; k < 4; k++) begin
      cc = 2 * c + (k & 1);
      rr = 2 * r + (k >> 1);
      s = touch(addr_of(cl, cc, rr));
      if (cell_refined[s] && cl < amr_pkg::MAX_LEVEL) begin
        acc += weighted_below(cl, cc, rr);
      end else begin
        acc += longint'($signed(cell_value[s])) <<< (2 * (amr_pkg::MAX_LEVEL - cl));
      end
    end
    return acc;
  endfunction

  function automatic logic [31:0] remap_of(int l, int c, int r);
    int     s;
    int     d;
    int     k;
    longint q;
    if (!on_mesh(l, c, r)) return '0;
    for (int pl = 0; pl <= l; pl++) begin
      d = l - pl;
      s = touch(addr_of(pl, c >> d, r >> d));
      if (!cell_refined[s] || pl == amr_pkg::MAX_LEVEL) return cell_value[s];
    end
    k = 2 * (amr_pkg::MAX_LEVEL - l);
    q = weighted_below(l, c, r);
    if (k > 0) q += longint'(1) <<< (k - 1);
    q = q >>> k;
    if (q > 64'sd2147483647) return 32'h7fff_ffff;
    if (q < -64'sd2147483648) return 32'h8000_0000;
    return q[31:0];
  endfunction

  task automatic issue(cell_req_t q, bit known, logic [31:0] remap);
    if (q.cmd == amr_pkg::CMD_QUERY) begin
      remap_due.push_back(known ? remap : remap_of(int'(q.lev), int'(q.col), int'(q.row)));
    end else begin
      store_cell(int'(q.lev), int'(q.col), int'(q.row), q.val);
    end
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {q.val, q.row, q.col, q.lev, q.cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    issued++;
  endtask

  // a query whose walk stays on written entries
  function automatic cell_req_t pick_query();
    cell_req_t   q;
    logic [31:0] dummy;
    for (int t = 0; t < 30; t++) begin
      q.cmd = amr_pkg::CMD_QUERY;
      q.val = $urandom;
      if ($urandom_range(99) < 8) begin
        q.lev = amr_pkg::LEV_W'($urandom_range(7));
        q.col = 6'($urandom_range(63));
        q.row = 6'($urandom_range(63));
      end else begin
        q.lev = amr_pkg::LEV_W'($urandom_range(amr_pkg::MAX_LEVEL));
        q.col = 6'($urandom_range((amr_pkg::BASE_SIZE << q.lev) - 1));
        q.row = 6'($urandom_range((amr_pkg::BASE_SIZE << q.lev) - 1));
      end
      unwritten_hit = 1'b0;
      dummy = remap_of(int'(q.lev), int'(q.col), int'(q.row));
      if (!unwritten_hit) return q;
    end
    q.lev = 3'd7;
    return q;
  endfunction

  function automatic logic [31:0] leaf_value();
    case ($urandom_range(7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic void grow(int l, int c, int r, bit deep);
    cell_req_t q;
    int        pct;
    pct = (l == 0) ? 50 : (l == 1) ? 40 : 25;
    if (l < amr_pkg::MAX_LEVEL && (deep || $urandom_range(99) < pct)) begin
      for (int k = 0; k < 4; k++) grow(l + 1, 2 * c + (k & 1), 2 * r + (k >> 1), deep);
    end else begin
      q.cmd = amr_pkg::CMD_INSERT;
      q.lev = amr_pkg::LEV_W'(l);
      q.col = 6'(c);
      q.row = 6'(r);
      q.val = leaf_value();
      mesh_cells.push_back(q);
    end
  endfunction

  step_row_t steps[] = '{
    '{'{amr_pkg::CMD_QUERY,  3'd5, 6'd0,  6'd0,  32'h0},         1'b1, 32'h0},
    '{'{amr_pkg::CMD_QUERY,  3'd7, 6'd63, 6'd63, 32'hffff_ffff}, 1'b1, 32'h0},
    '{'{amr_pkg::CMD_QUERY,  3'd0, 6'd4,  6'd0,  32'h0},         1'b1, 32'h0},
    '{'{amr_pkg::CMD_QUERY,  3'd1, 6'd0,  6'd8,  32'h0},         1'b1, 32'h0},
    '{'{amr_pkg::CMD_INSERT, 3'd5, 6'd0,  6'd0,  32'hffff_ffff}, 1'b0, 32'h0},
    '{'{amr_pkg::CMD_INSERT, 3'd0, 6'd4,  6'd0,  32'h1234_0000}, 1'b0, 32'h0},
    '{'{amr_pkg::CMD_INSERT, 3'd0, 6'd0,  6'd0,  32'h7fff_ffff}, 1'b0, 32'h0},
    '{'{amr_pkg::CMD_QUERY,  3'd0, 6'd0,  6'd0,  32'h0},         1'b1, 32'h7fff_ffff},
    '{'{amr_pkg::CMD_INSERT, 3'd0, 6'd1,  6'd0,  32'h8000_0000}, 1'b0, 32'h0},
    '{'{amr_pkg::CMD_QUERY,  3'd2, 6'd4,  6'd1,  32'h0},         1'b1, 32'h8000_0000},
    '{'{amr_pkg::CMD_INSERT, 3'd1, 6'd1,  6'd0,  32'h7fff_ffff}, 1'b0, 32'h0},
    '{'{amr_pkg::CMD_INSERT, 3'd1, 6'd0,  6'd1,  32'h7fff_ffff}, 1'b0, 32'h0},
    '{'{amr_pkg::CMD_INSERT, 3'd1, 6'd1,  6'd1,  32'h0000_0001}, 1'b0, 32'h0},
    '{'{amr_pkg::CMD_INSERT, 3'd1, 6'd0,  6'd0,  32'h8000_0000}, 1'b0, 32'h0},
    '{'{amr_pkg::CMD_QUERY,  3'd0, 6'd0,  6'd0,  32'h0},         1'b0, 32'h0},
    '{'{amr_pkg::CMD_QUERY,  3'd2, 6'd1,  6'd1,  32'h0},         1'b0, 32'h0},
    '{'{amr_pkg::CMD_QUERY,  3'd1, 6'd1,  6'd1,  32'h0},         1'b0, 32'h0},
    '{'{amr_pkg::CMD_INSERT, 3'd0, 6'd0,  6'd0,  32'h1234_5678}, 1'b0, 32'h0},
    '{'{amr_pkg::CMD_QUERY,  3'd1, 6'd1,  6'd1,  32'h0},         1'b1, 32'h1234_5678}
  };

  initial begin
    int        mesh_no;
    cell_req_t q;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    gap_pct = 0;
    stall_pct = 0;
    pressure_go = 1'b0;
    issued = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (steps[i]) issue(steps[i].req, steps[i].known, steps[i].remap);
    mesh_no = 0;
    while (issued < 1500) begin
      case (mesh_no % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 86; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 86; end
        default: begin gap_pct = 35; stall_pct = 35; end
      endcase
      if (mesh_no == 0) pressure_go = 1'b1;
      mesh_cells.delete();
      for (int b = 0; b < amr_pkg::BASE_SIZE * amr_pkg::BASE_SIZE; b++) begin
        grow(0, b % amr_pkg::BASE_SIZE, b / amr_pkg::BASE_SIZE,
             mesh_no % 5 == 3 && (b == 0 || b == amr_pkg::BASE_SIZE * amr_pkg::BASE_SIZE - 1));
      end
      mesh_cells.shuffle();
      foreach (mesh_cells[i]) begin
        if ($urandom_range(99) < 4) begin
          q.cmd = amr_pkg::CMD_INSERT;
          q.lev = amr_pkg::LEV_W'($urandom_range(7));
          q.col = 6'($urandom_range(63));
          q.row = 6'($urandom_range(63));
          q.val = $urandom;
          issue(q, 1'b0, '0);
        end
        issue(mesh_cells[i], 1'b0, '0);
      end
      for (int n = 0; n < 60; n++) issue(pick_query(), 1'b0, '0);
      mesh_no++;
    end
    in_tvalid <= 1'b0;
    while (remap_due.size() != 0) @(posedge clk);
    repeat (800) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // result side, with one long hold-off so the request side backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (pressure_go && held < HOLD_CYCLES) begin
      out_tready <= 1'b0;
      held <= held + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (remap_due.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result %h", out_tdata);
      end else begin
        if (out_tdata !== remap_due[0]) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) begin
            $display("remap mismatch: expected %h got %h", remap_due[0], out_tdata);
          end
        end
        void'(remap_due.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end
endmodule
